// ===== hdl/tbs_pkg.sv =====
// tbs_pkg: types and constants for the track box smoother.
// Used by tbs_ctrl, tbs_datapath and track_box_smoother.
package tbs_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 8;
  localparam int SMOOTH_BITS = COORD_BITS + FRAC_BITS;
  localparam int CONF_BITS   = FRAC_BITS + 1;
  localparam int DIV_STEPS   = SMOOTH_BITS + FRAC_BITS;

  localparam logic [CONF_BITS-1:0] CONF_ONE  = CONF_BITS'(1 << FRAC_BITS);
  localparam logic [CONF_BITS-1:0] CONF_INIT = CONF_BITS'(((1 << FRAC_BITS) * 9) / 10);
  localparam logic [7:0] LOST_PREDICT = 8'd5;
  localparam logic [7:0] LOST_GIVEUP  = 8'd15;
  localparam logic [7:0] ALPHA_MIN    = 8'd26;
  localparam logic [7:0] ALPHA_MAX    = 8'd230;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_INIT   = 2'd1,
    FUNC_RESET  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_DETECTING  = 2'd0,
    MODE_TRACKING   = 2'd1,
    MODE_PREDICTING = 2'd2,
    MODE_LOST       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_BLEND  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start a size ratio division
    logic div_sel;    // 0 width, 1 height
    logic commit;     // write the next state for the captured item
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== hdl/tbs_ctrl.sv =====
// tbs_ctrl: sequencer for one item: capture, two ratio divisions, commit, output.
// Depends on tbs_pkg.
module tbs_ctrl import tbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_load
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIVW  = 7'b0000010,
    S_WAITW = 7'b0000100,
    S_DIVH  = 7'b0001000,
    S_WAITH = 7'b0010000,
    S_COMMIT= 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAITW;
      end
      S_WAITW: begin
        if (!stat.div_busy) state_nxt = S_DIVH;
      end
      S_DIVH: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = S_WAITH;
      end
      S_WAITH: begin
        cmd.div_sel = 1'b1;
        if (!stat.div_busy) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/tbs_datapath.sv =====
// tbs_datapath: smoothing state, restoring divider, blend and box clamp.
// Depends on tbs_pkg; commanded by tbs_ctrl.
module tbs_datapath import tbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [1:0]            cfg_we_idx,
  input  logic                  cfg_we,
  input  logic [11:0]           cfg_data,
  input  logic [1:0]            in_func,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic [COORD_BITS-1:0] in_w,
  input  logic [COORD_BITS-1:0] in_h,
  input  logic                  in_found,
  output logic                  res_ok,
  output logic [COORD_BITS-1:0] res_left,
  output logic [COORD_BITS-1:0] res_top,
  output logic [COORD_BITS-1:0] res_width,
  output logic [COORD_BITS-1:0] res_height,
  output logic [CONF_BITS-1:0]  res_conf,
  output logic [1:0]            res_mode
);

  localparam int SB = SMOOTH_BITS;
  localparam int DB = DIV_STEPS;
  localparam int CB = $clog2(DB + 1);

  // configuration
  logic [7:0]            alpha_r;
  logic [COORD_BITS-1:0] fw_r, fh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 8'd77;
      fw_r    <= COORD_BITS'(640);
      fh_r    <= COORD_BITS'(480);
    end else if (cfg_we) begin
      case (cfg_we_idx)
        REG_BLEND: begin
          if (cfg_data[7:0] < ALPHA_MIN)      alpha_r <= ALPHA_MIN;
          else if (cfg_data[7:0] > ALPHA_MAX) alpha_r <= ALPHA_MAX;
          else                                alpha_r <= cfg_data[7:0];
        end
        REG_WIDTH:  fw_r <= (cfg_data == '0) ? COORD_BITS'(1) : cfg_data[COORD_BITS-1:0];
        REG_HEIGHT: fh_r <= (cfg_data == '0) ? COORD_BITS'(1) : cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // state
  logic [SB-1:0]        cx_r, cy_r, ws_r, hs_r;
  logic [CONF_BITS-1:0] conf_r;
  logic [7:0]           lost_r;
  logic [1:0]           mode_r;
  logic                 armed_r;

  // captured item
  logic [1:0]            f_r;
  logic [COORD_BITS-1:0] x_r, y_r, w_r, h_r;
  logic                  fnd_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_r <= in_func; x_r <= in_x; y_r <= in_y; w_r <= in_w; h_r <= in_h;
      fnd_r <= in_found;
    end
  end

  // Q forms of the item (wq and hq fit in SB bits; cxq and cyq saturate to SB bits)
  logic [SB-1:0] wq, hq, cxq, cyq;
  assign wq  = {w_r, {FRAC_BITS{1'b0}}};
  assign hq  = {h_r, {FRAC_BITS{1'b0}}};
  assign cxq = SB'({1'b0, x_r, {FRAC_BITS{1'b0}}} + {2'b0, w_r, {(FRAC_BITS-1){1'b0}}} >= (1 << SB)
               ? {SB{1'b1}} : ({1'b0, x_r, {FRAC_BITS{1'b0}}} + {2'b0, w_r, {(FRAC_BITS-1){1'b0}}}));
  assign cyq = SB'({1'b0, y_r, {FRAC_BITS{1'b0}}} + {2'b0, h_r, {(FRAC_BITS-1){1'b0}}} >= (1 << SB)
               ? {SB{1'b1}} : ({1'b0, y_r, {FRAC_BITS{1'b0}}} + {2'b0, h_r, {(FRAC_BITS-1){1'b0}}}));

  // restoring divider: (|new - smooth| << FRAC_BITS) / smooth, one quotient bit per cycle
  logic [SB-1:0] dnew, dsm, dabs;
  assign dnew = cmd.div_sel ? hq : wq;
  assign dsm  = cmd.div_sel ? hs_r : ws_r;
  assign dabs = (dnew > dsm) ? dnew - dsm : dsm - dnew;

  logic [DB-1:0] dvd_r, quo_r;
  logic [SB:0]   rem_r;
  logic [SB-1:0] dvs_r;
  logic [CB-1:0] cnt_r;
  logic          dbusy_r;
  logic [SB:0]   trial;
  assign trial = {rem_r[SB-1:0], dvd_r[DB-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) dbusy_r <= 1'b0;
    else if (cmd.div_start) dbusy_r <= 1'b1;
    else if (dbusy_r && cnt_r == CB'(DB - 1)) dbusy_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= {dabs, {FRAC_BITS{1'b0}}};
      dvs_r <= dsm;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (dbusy_r) begin
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r + CB'(1);
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= trial - {1'b0, dvs_r};
        quo_r <= {quo_r[DB-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[DB-2:0], 1'b0};
      end
    end
  end
  assign stat.div_busy = dbusy_r;

  // clipped ratio, zero divisor counts as one
  logic [CONF_BITS-1:0] ratio, rw_r;
  assign ratio = (dvs_r == '0 || quo_r > DB'(CONF_ONE)) ? CONF_ONE : quo_r[CONF_BITS-1:0];
  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel) rw_r <= ratio;
  end

  // confidence from the two ratios
  logic [CONF_BITS+1:0] pen;
  logic [CONF_BITS-1:0] conf_upd;
  assign pen      = {1'b0, rw_r, 1'b0} + {1'b0, ratio, 1'b0};
  assign conf_upd = (pen >= (CONF_BITS+2)'(CONF_ONE)) ? '0 : CONF_ONE - pen[CONF_BITS-1:0];

  function automatic logic [SB-1:0] blend_f(logic [SB-1:0] s, logic [SB-1:0] v,
                                            logic [7:0] a);
    logic [SB+9:0] acc;
    acc = (SB+10)'(v) * a + (SB+10)'(s) * (9'd256 - {1'b0, a}) + (SB+10)'(128);
    return acc[SB+7:8];
  endfunction

  logic upd_hit, init_bad;
  assign upd_hit  = fnd_r && w_r != '0 && h_r != '0;
  assign init_bad = w_r == '0 || h_r == '0 ||
                    ({1'b0, x_r} + {1'b0, w_r} > {1'b0, fw_r}) ||
                    ({1'b0, y_r} + {1'b0, h_r} > {1'b0, fh_r});

  logic [7:0] lost_inc;
  assign lost_inc = (lost_r == 8'hFF) ? lost_r : lost_r + 8'd1;

  logic show_box_r, ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; ws_r <= '0; hs_r <= '0;
      conf_r <= '0; lost_r <= '0; mode_r <= MODE_DETECTING; armed_r <= 1'b0;
      show_box_r <= 1'b0; ok_r <= 1'b0;
    end else if (cmd.commit) begin
      show_box_r <= 1'b0;
      ok_r       <= 1'b0;
      case (f_r)
        FUNC_RESET: begin
          cx_r <= '0; cy_r <= '0; ws_r <= '0; hs_r <= '0;
          conf_r <= '0; lost_r <= '0; mode_r <= MODE_DETECTING; armed_r <= 1'b0;
        end
        FUNC_INIT: begin
          if (init_bad) armed_r <= 1'b0;
          else begin
            cx_r <= cxq; cy_r <= cyq; ws_r <= wq; hs_r <= hq;
            conf_r <= CONF_INIT; lost_r <= '0; mode_r <= MODE_TRACKING;
            armed_r <= 1'b1; show_box_r <= 1'b1; ok_r <= 1'b1;
          end
        end
        FUNC_UPDATE: begin
          if (armed_r) begin
            show_box_r <= 1'b1;
            if (upd_hit) begin
              ok_r   <= 1'b1;
              conf_r <= conf_upd;
              lost_r <= '0;
              cx_r <= blend_f(cx_r, cxq, alpha_r);
              cy_r <= blend_f(cy_r, cyq, alpha_r);
              ws_r <= blend_f(ws_r, wq, alpha_r);
              hs_r <= blend_f(hs_r, hq, alpha_r);
              mode_r <= ((CONF_BITS+4)'(conf_upd) * 10 > (CONF_BITS+4)'(CONF_ONE) * 3)
                        ? MODE_TRACKING : MODE_PREDICTING;
            end else begin
              lost_r <= lost_inc;
              conf_r <= '0;
              if (lost_inc > LOST_GIVEUP)       mode_r <= MODE_LOST;
              else if (lost_inc > LOST_PREDICT) mode_r <= MODE_PREDICTING;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // box clamp from state
  function automatic logic [COORD_BITS-1:0] edge_f(logic [SB-1:0] c, logic [SB-1:0] s,
                                                   logic [COORD_BITS-1:0] lim);
    logic [SB:0] twice;
    logic [SB:0] diff;
    logic [COORD_BITS-1:0] e;
    twice = {c, 1'b0};
    diff  = twice - {1'b0, s};
    e     = diff[SB:FRAC_BITS+1];
    if (twice <= {1'b0, s}) return '0;
    return (e > lim - COORD_BITS'(1)) ? lim - COORD_BITS'(1) : e;
  endfunction

  function automatic logic [COORD_BITS-1:0] size_f(logic [SB-1:0] s,
                                                   logic [COORD_BITS-1:0] lim,
                                                   logic [COORD_BITS-1:0] e);
    logic [COORD_BITS-1:0] v, hi;
    v  = s[SB-1:FRAC_BITS];
    hi = lim - e;
    if (v == '0) v = COORD_BITS'(1);
    return (v > hi) ? hi : v;
  endfunction

  logic [COORD_BITS-1:0] l_c, t_c;
  assign l_c = edge_f(cx_r, ws_r, fw_r);
  assign t_c = edge_f(cy_r, hs_r, fh_r);

  assign res_ok     = ok_r;
  assign res_left   = show_box_r ? l_c : '0;
  assign res_top    = show_box_r ? t_c : '0;
  assign res_width  = show_box_r ? size_f(ws_r, fw_r, l_c) : '0;
  assign res_height = show_box_r ? size_f(hs_r, fh_r, t_c) : '0;
  assign res_conf   = show_box_r ? conf_r : '0;
  assign res_mode   = mode_r;

endmodule

// ===== hdl/track_box_smoother.sv =====
// track_box_smoother: top level, stream ports, output register, assertions.
// Depends on tbs_pkg, tbs_ctrl and tbs_datapath.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata {box fields}, in_tuser {found, func}
//  out_    | out | out_tvalid/out_tready| out_tdata {box, confidence}, out_tuser {mode, ok}
//  cfg_    | in  | cfg_we               | cfg_idx, cfg_wdata
//
// An item goes through capture, the width ratio division, the height ratio
// division, commit and output load in that order; its time is set by the
// bit-per-cycle restoring divider run twice (width and height ratios).
// One item is in work at a time; in_tready is high only while idle.
// The output register holds a result until taken; a stalled out_tready holds
// the next item in its final step. Reset (rst_n low, synchronous) restores
// registers to 77/640/480 and clears the tracking state and valid flags; no clearing pass.
module track_box_smoother import tbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // box_left, box_top, box_width, box_height
  input  logic [2:0]  in_tuser,  // func[1:0], found[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // out_left, out_top, out_width, out_height, confidence_level
  output logic [2:0]  out_tuser, // ok[0], mode[2:1]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [11:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy, out_load, in_fire, out_free;

  logic                  r_ok;
  logic [COORD_BITS-1:0] r_l, r_t, r_w, r_h;
  logic [CONF_BITS-1:0]  r_c;
  logic [1:0]            r_m;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;

  tbs_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .stat, .cmd, .busy, .out_load
  );

  tbs_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .cfg_we_idx(cfg_idx), .cfg_we, .cfg_data(cfg_wdata),
    .in_func(in_tuser[1:0]), .in_x(in_tdata[11:0]), .in_y(in_tdata[23:12]),
    .in_w(in_tdata[35:24]), .in_h(in_tdata[47:36]), .in_found(in_tuser[2]),
    .res_ok(r_ok), .res_left(r_l), .res_top(r_t), .res_width(r_w),
    .res_height(r_h), .res_conf(r_c), .res_mode(r_m)
  );

  // output register
  logic        ovalid_r;
  logic [63:0] odata_r;
  logic [2:0]  ouser_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (out_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      odata_r <= {7'b0, r_c, r_h, r_w, r_t, r_l};
      ouser_r <= {r_m, r_ok};
    end
  end
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("transfer accepted while busy");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free) else $error("result overwrote a pending output");
  a_ok_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[35:24] != 12'd0))
    else $error("ok result with zero width");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy) else $error("divider restarted while busy");

endmodule
